@@ src/ois_pkg.sv @@
// Shared types and constants for the ordered integer set.
// No dependencies; imported by ois_mem, ois_ctrl and ordered_integer_set_top.
`default_nettype none

package ois_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = 4;
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HAVE    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              present;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] data;
    } result_t;

endpackage

`default_nettype wire

@@ src/ois_mem.sv @@
// Entry store: one write port, one read port with registered read data.
// Depends on ois_pkg.
`default_nettype none

module ois_mem
    import ois_pkg::*;
(
    input  wire logic              aclk,
    input  wire mem_req_t          req,
    output logic      [DATA_W-1:0] q
);

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            q <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/ois_ctrl.sv @@
// Sequencer: walks the entry store to search, shifts entries down on
// remove, and builds one result per item. Depends on ois_pkg.
`default_nettype none

module ois_ctrl
    import ois_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_action,
    input  wire logic [DATA_W-1:0] in_value,
    input  wire logic [ADDR_W-1:0] in_index,
    output mem_req_t               mem_req,
    input  wire logic [DATA_W-1:0] mem_q,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [1:0]        act_reg, act_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              present_reg, present_next;
    logic [1:0]        status_reg, status_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        act_reg       <= act_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        present_reg   <= present_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
    end

    assign hit = pend_reg && (mem_q == val_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        present_next   = present_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        mem_req        = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    act_next   = in_action;
                    val_next   = in_value;
                    idx_next   = in_index;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || (ptr_reg == count_reg)) begin
                    // search settled: apply the action
                    present_next = hit;
                    status_next  = ST_OK;
                    data_next    = '0;
                    pend_next    = 1'b0;
                    state_next   = S_DONE;
                    case (act_reg)
                        ACT_INSERT: begin
                            if (hit) begin
                                status_next = ST_HAVE;
                            end else if (count_reg == CAP_CNT) begin
                                status_next = ST_REFUSED;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[ADDR_W-1:0];
                                mem_req.wdata = val_reg;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!hit) begin
                                status_next = ST_MISSING;
                            end else begin
                                count_next = count_reg - 1'b1;
                                ptr_next   = {1'b0, pend_addr_reg} + 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_QUERY: begin
                            if (!hit) begin
                                status_next = ST_MISSING;
                            end
                        end
                        default: begin
                            if ({1'b0, idx_reg} < count_reg) begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = idx_reg;
                                state_next    = S_RDWAIT;
                            end else begin
                                status_next = ST_REFUSED;
                            end
                        end
                    endcase
                end else begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = ptr_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                // write each fetched entry one place lower
                if (pend_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg - 1'b1;
                    mem_req.wdata = mem_q;
                end
                if (ptr_reg <= count_reg) begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = ptr_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RDWAIT: begin
                data_next  = mem_q;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.present = present_reg;
    assign res.status  = status_reg;
    assign res.count   = count_reg;
    assign res.data    = data_reg;

endmodule

`default_nettype wire

@@ src/ordered_integer_set_top.sv @@
// Ordered integer set: top level with output register and checks.
// Each item is accepted, the stored entries are searched in order and the
// result is held; remove of a present value adds a shift-down of later
// entries, a good read adds a read wait. Throughput: one item at a time,
// bounded by the entry store's single read port, one entry per cycle.
// Reset: entry count cleared to zero (set empty); entry store not cleared.
`default_nettype none

module ordered_integer_set_top
    import ois_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_action,
    input  wire logic signed [DATA_W-1:0] s_value,
    input  wire logic [ADDR_W-1:0]        s_index,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_present,
    output logic [1:0]                    m_status,
    output logic [CNT_W-1:0]              m_count,
    output logic signed [DATA_W-1:0]      m_read_data
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_q;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_valid_reg;
    result_t           out_reg;

    // Entry store: the whole set lives here.
    ois_mem u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .q    (mem_q)
    );

    // Sequencer: search, insert, shift-down on remove, indexed read.
    ois_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_action (s_action),
        .in_value  (s_value),
        .in_index  (s_index),
        .mem_req   (mem_req),
        .mem_q     (mem_q),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: take a new result beat when empty or being drained,
    // so the sequencer can return to idle while a result still waits.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // Hold the payload while the beat waits; advance only on a new result.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_present   = out_reg.present;
    assign m_status    = out_reg.status;
    assign m_count     = out_reg.count;
    assign m_read_data = out_reg.data;

    // The set never reports more entries than it can hold.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_count <= CAP_CNT))
        else $error("count above capacity");

    // Only a good read returns nonzero data.
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_data != '0)) |-> (m_status == ST_OK))
        else $error("read data on a failed or non-read beat");

    // Already-present status implies the presence flag; missing implies not.
    a_have_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_HAVE)) |-> m_present)
        else $error("already-present status without presence");

    a_missing_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_MISSING)) |-> !m_present)
        else $error("missing status with presence");

endmodule

`default_nettype wire
